### rtl/ild_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ild_pkg
// Shared types, constants and coefficient table for the IIR lowpass
// decimator: a six-section direct-form-I biquad cascade with fixed Q2.30
// coefficients and Q4.27 section history.
// ----------------------------------------------------------------------------
package ild_pkg;

   // Build defaults
   localparam int SECTIONS_DEF    = 6;
   localparam int SAMPLE_BITS_DEF = 16;

   // Cascade limits and widths
   localparam int MAX_SECTIONS = 8;
   localparam int MAX_SEC_W    = 3;
   localparam int TAPS         = 5;
   localparam int TAP_W        = 3;
   localparam int HIST_W       = 32;
   localparam int PROD_W       = 64;
   localparam int RATIO_W      = 8;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd10;

   // Tap order within a section: b0, b1, b2, a1, a2
   localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
   localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
   localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
   localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
   localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

   // Coefficients in Q2.30; the a terms are stored negated.
   // Sections beyond the sixth pass their input straight through.
   localparam logic signed [HIST_W-1:0] COEF_Q30 [MAX_SECTIONS][TAPS] = '{
      '{ 32'sd11205785,  32'sd22411570,  32'sd11205785,
         32'sd2041445760, -32'sd1012527040 },
      '{ 32'sd10624605,  32'sd21249210,  32'sd10624605,
         32'sd1935567615, -32'sd904324160 },
      '{ 32'sd10162486,  32'sd20324972,  32'sd10162486,
         32'sd1851379712, -32'sd818287872 },
      '{ 32'sd9829672,   32'sd19659344,  32'sd9829672,
         32'sd1790748416, -32'sd756325248 },
      '{ 32'sd9629619,   32'sd19259238,  32'sd9629619,
         32'sd1754303232, -32'sd719079872 },
      '{ 32'sd101331792, 32'sd101331792, 32'sd0,
         32'sd871078208,  32'sd0 },
      '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
      '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 }
   };

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_UPDATE,
      ST_FINISH
   } ild_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                 load_in;   // capture the accepted sample
      logic                 mac_en;    // issue one product, accumulate the last
      logic                 update;    // round, saturate, shift section history
      logic                 commit;    // advance the decimation counter
      logic                 load_out;  // fill the result register
      logic [TAP_W-1:0]     tap;
      logic [MAX_SEC_W-1:0] sec;
   } ild_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic emit;      // this sample is one to pass out
      logic out_free;  // result register can take a new value
   } ild_status_type;

endpackage : ild_pkg
`default_nettype wire

### rtl/iir_lowpass_decimator.sv
`default_nettype none
// Processing: one sample at a time; for each section in turn, five products
//   on one multiplier and a rounding step, then a decision on emission that
//   holds while an earlier result is still stalled, and a return to idle.
// Reset: synchronous, clears section history and the decimation count and
//   sets the ratio to 10; the block is ready for a sample right after.
// ----------------------------------------------------------------------------
// iir_lowpass_decimator
// Eleventh-order Butterworth lowpass as a cascade of direct-form-I biquads,
// followed by a decimator that passes one sample in every N, saturated to
// the sample width with a clip flag.
// ----------------------------------------------------------------------------
module iir_lowpass_decimator
   import ild_pkg::*;
#(
   parameter int SECTIONS    = SECTIONS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int DATA_W     = 8 * ((SAMPLE_BITS + 7) / 8)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // sample input
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,   // [SAMPLE_BITS-1:0] sample_in, rest zero
   // decimated result
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // [SAMPLE_BITS-1:0] filtered_out, rest zero
   output logic                   rsp_tuser,   // [0] saturated
   // decimation ratio write
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [RATIO_W-1:0] csr_data
);

   ild_cmd_type            cmd;
   ild_status_type         status;
   logic [SAMPLE_BITS-1:0] filtered_out;

   ild_ctrl #(
      .SECTIONS (SECTIONS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ild_datapath #(
      .SECTIONS    (SECTIONS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .sample_in    (req_tdata[SAMPLE_BITS-1:0]),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .filtered_out (filtered_out),
      .saturated    (rsp_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready)
   );

   // Ratio register takes a write in any cycle
   assign csr_ready = 1'b1;
   assign rsp_tdata = DATA_W'(filtered_out);

endmodule : iir_lowpass_decimator
`default_nettype wire

### rtl/ild_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ild_ctrl
// Sequencer for the decimator: steps the shared multiply-accumulate through
// five taps per section, then one rounding step, for every section in turn,
// and finally decides whether the sample is emitted.
// ----------------------------------------------------------------------------
module ild_ctrl
   import ild_pkg::*;
#(
   parameter int SECTIONS = SECTIONS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire ild_status_type status,
   output ild_cmd_type         cmd
);

   localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   ild_state_type    state_ff, state_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic [SEC_W-1:0] sec_ff, sec_in;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
         sec_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         sec_ff   <= sec_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      sec_in       = sec_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.tap      = tap_ff;
      cmd.sec      = MAX_SEC_W'(sec_ff);
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               tap_in      = '0;
               sec_in      = '0;
               state_in    = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mac_en = 1'b1;
            if (tap_ff == TAP_W'(TAPS - 1)) begin
               state_in = ST_UPDATE;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            tap_in     = '0;
            if (sec_ff == SEC_W'(SECTIONS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               sec_in   = sec_ff + 1'b1;
               state_in = ST_MAC;
            end
         end
         ST_FINISH: begin
            // hold while a due result cannot yet enter the output register
            if (!status.emit) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.out_free) begin
               cmd.commit   = 1'b1;
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : ild_ctrl
`default_nettype wire

### rtl/ild_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ild_datapath
// Shared 32x32 multiplier with a 64-bit accumulator, section history
// registers, rounding and saturation to Q4.27, decimation counter, ratio
// register and the result register.
// ----------------------------------------------------------------------------
module ild_datapath
   import ild_pkg::*;
#(
   parameter int SECTIONS    = SECTIONS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ild_cmd_type            cmd,
   output ild_status_type              status,
   input  wire logic [SAMPLE_BITS-1:0] sample_in,
   input  wire logic                   csr_valid,
   input  wire logic [RATIO_W-1:0]     csr_data,
   output logic [SAMPLE_BITS-1:0]      filtered_out,
   output logic                        saturated,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready
);

   localparam int SEC_W       = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int WIDEN_SHIFT = 28 - SAMPLE_BITS;
   localparam int RND_W       = HIST_W + 1 - WIDEN_SHIFT;

   logic signed [HIST_W-1:0] hist_ff [SECTIONS][4];
   logic signed [HIST_W-1:0] x_ff, x_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic [RATIO_W-1:0]       count_ff, count_in;
   logic [RATIO_W-1:0]       ratio_ff;
   logic [RATIO_W-1:0]       count_inc;
   logic [SAMPLE_BITS-1:0]   out_data_ff, out_data_in;
   logic                     out_sat_ff, out_sat_in;
   logic                     out_valid_ff;

   logic [SEC_W-1:0]         sec;
   logic signed [HIST_W-1:0] coef_sel;
   logic signed [HIST_W-1:0] op_sel;
   logic signed [PROD_W-1:0] sum;
   logic signed [PROD_W-1:0] rnd_full;
   logic signed [33:0]       rnd_q;
   logic signed [HIST_W-1:0] y;
   logic signed [HIST_W:0]   out_wide;
   logic [RND_W-1:0]         out_q;
   logic                     out_clip;

   assign sec = cmd.sec[SEC_W-1:0];

   // Select coefficient and operand for the current tap
   always_comb begin
      coef_sel = COEF_Q30[cmd.sec][cmd.tap];
      case (cmd.tap)
         TAP_B0:  op_sel = x_ff;
         TAP_B1:  op_sel = hist_ff[sec][0];
         TAP_B2:  op_sel = hist_ff[sec][1];
         TAP_A1:  op_sel = hist_ff[sec][2];
         TAP_A2:  op_sel = hist_ff[sec][3];
         default: op_sel = '0;
      endcase
   end

   // Product of this tap; accumulate the previous product
   assign prod_in = coef_sel * op_sel;
   assign acc_in  = (cmd.tap == TAP_B0) ? '0 : acc_ff + prod_ff;

   // Section output: add the last product, round to Q4.27, saturate
   always_comb begin
      sum      = acc_ff + prod_ff;
      rnd_full = sum + 64'sd536870912;
      rnd_q    = rnd_full[PROD_W-1:30];
      if ((rnd_q[33:31] == 3'b000) || (rnd_q[33:31] == 3'b111)) begin
         y = rnd_q[HIST_W-1:0];
      end else if (rnd_q[33]) begin
         y = {1'b1, {(HIST_W-1){1'b0}}};
      end else begin
         y = {1'b0, {(HIST_W-1){1'b1}}};
      end
   end

   // Widen the new sample with sign extension, or pass the section output on
   always_comb begin
      x_in = x_ff;
      if (cmd.load_in) begin
         x_in = {{(HIST_W - 28){sample_in[SAMPLE_BITS-1]}}, sample_in, {WIDEN_SHIFT{1'b0}}};
      end else if (cmd.update) begin
         x_in = y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (cmd.mac_en) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   // Shift the section history on each section update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SECTIONS; s++) begin
            for (int h = 0; h < 4; h++) begin
               hist_ff[s][h] <= '0;
            end
         end
      end else if (cmd.update) begin
         hist_ff[sec][1] <= hist_ff[sec][0];
         hist_ff[sec][0] <= x_ff;
         hist_ff[sec][3] <= hist_ff[sec][2];
         hist_ff[sec][2] <= y;
      end
   end

   // Decimation: saturating count, emit when it reaches or passes the ratio
   assign count_inc   = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign status.emit = (count_inc >= ratio_ff);
   assign count_in    = status.emit ? '0 : count_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ratio_ff <= RATIO_RESET;
      end else begin
         if (cmd.commit) begin
            count_ff <= count_in;
         end
         if (csr_valid) begin
            ratio_ff <= csr_data;
         end
      end
   end

   // Round the last section output half up to the sample format, saturate
   always_comb begin
      out_wide = {x_ff[HIST_W-1], x_ff} + (HIST_W + 1)'(1 << (WIDEN_SHIFT - 1));
      out_q    = out_wide[HIST_W:WIDEN_SHIFT];
      out_clip = !((&out_q[RND_W-1:SAMPLE_BITS-1]) || (~|out_q[RND_W-1:SAMPLE_BITS-1]));
      if (!out_clip) begin
         out_data_in = out_q[SAMPLE_BITS-1:0];
      end else if (out_q[RND_W-1]) begin
         out_data_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         out_data_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      out_sat_in = out_clip;
   end

   // Result register: fill on load, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff <= out_data_in;
         out_sat_ff  <= out_sat_in;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign filtered_out    = out_data_ff;
   assign saturated       = out_sat_ff;

endmodule : ild_datapath
`default_nettype wire

### rtl/ild_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ild_checker
// Port-level checks for the decimator: result hold under back-pressure,
// one sample in flight at a time, new results only on return to idle, and readiness after reset.
// ----------------------------------------------------------------------------
module ild_checker
   import ild_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int DATA_W     = 8 * ((SAMPLE_BITS + 7) / 8)
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic [DATA_W-1:0] req_tdata,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [DATA_W-1:0] rsp_tdata,
   input wire logic              rsp_tuser,
   input wire logic              csr_valid,
   input wire logic              csr_ready,
   input wire logic [RATIO_W-1:0] csr_data
);

   // Stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Ready falls straight after a sample is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample taken while one is in flight");

   // A new result appears only as the block returns to idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result presented while a sample is still in flight");

   // Ready for a sample straight after reset
   assert property (@(posedge clock)
      $fell(reset) |-> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule : ild_checker

bind iir_lowpass_decimator ild_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);
`default_nettype wire

### tb/iir_lowpass_decimator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_lowpass_decimator_test
// Self-checking bench for the IIR lowpass decimator. A bit-exact software copy
// of the six-section biquad cascade and the decimation counter predicts every
// emitted sample and its clip flag. Directed runs cover sample extremes, the
// reset ratio, ratio one and zero, and a ratio lowered below the running
// count. Random phases follow, mixing full-scale steps, noise and quiet
// stretches under several ratios and idle patterns on both streams.
// ----------------------------------------------------------------------------
module iir_lowpass_decimator_test
   import ild_pkg::*;
;

   localparam int SAMPLE_W      = 16;
   localparam int N_SECTIONS    = 6;
   localparam int SETTLE_CYCLES = 60;

   // b0 b1 b2 a1 a2 per section in Q2.30, a terms negated
   localparam int LPF_COEF [N_SECTIONS][5] = '{
      '{11205785, 22411570, 11205785, 2041445760, -1012527040},
      '{10624605, 21249210, 10624605, 1935567615, -904324160},
      '{10162486, 20324972, 10162486, 1851379712, -818287872},
      '{9829672, 19659344, 9829672, 1790748416, -756325248},
      '{9629619, 19259238, 9629619, 1754303232, -719079872},
      '{101331792, 101331792, 0, 871078208, 0}
   };

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum {SEG_STEP, SEG_NOISE, SEG_QUIET} segment_kind_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic                       clipped;
   } decimated_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [SAMPLE_W-1:0]        req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]        rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [RATIO_W-1:0]         csr_data   = '0;

   // Software copy of the filter state and the decimator
   logic signed [31:0]         section_mem [4*N_SECTIONS];
   logic [7:0]                 sample_count;
   logic [7:0]                 ratio_shadow;
   decimated_type              due_results [$];

   int                         send_idle_pct = 0;
   int                         recv_stall_pct = 0;
   int                         error_count = 0;

   iir_lowpass_decimator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] sample_in
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] filtered_out
      .rsp_tuser  (rsp_tuser),   // [0] saturated
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic clear_filter_model();
      foreach (section_mem[k]) section_mem[k] = '0;
      sample_count = '0;
      ratio_shadow = RATIO_RESET;
   endtask

   // Run one sample through the cascade and queue a result when the
   // decimator fires
   function automatic void filter_sample(input logic signed [SAMPLE_W-1:0] s);
      logic signed [31:0] v;
      longint             acc;
      longint             y;
      decimated_type      d;
      v = {{4{s[SAMPLE_W-1]}}, s, 12'd0};
      for (int k = 0; k < N_SECTIONS; k++) begin
         acc = longint'(LPF_COEF[k][0]) * longint'(v)
             + longint'(LPF_COEF[k][1]) * longint'(section_mem[4*k])
             + longint'(LPF_COEF[k][2]) * longint'(section_mem[4*k+1])
             + longint'(LPF_COEF[k][3]) * longint'(section_mem[4*k+2])
             + longint'(LPF_COEF[k][4]) * longint'(section_mem[4*k+3]);
         y = (acc + (64'sd1 <<< 29)) >>> 30;
         if (y > 64'sd2147483647) y = 64'sd2147483647;
         else if (y < -64'sd2147483648) y = -64'sd2147483648;
         section_mem[4*k+1] = section_mem[4*k];
         section_mem[4*k]   = v;
         section_mem[4*k+3] = section_mem[4*k+2];
         section_mem[4*k+2] = y[31:0];
         v = y[31:0];
      end
      if (sample_count < 8'd255) sample_count++;
      if (sample_count < ratio_shadow) return;
      sample_count = '0;
      // Round half up back to the sample format, then clip
      y = (longint'(v) + 64'sd2048) >>> 12;
      d.clipped = 1'b0;
      if (y > 64'sd32767) begin
         y = 64'sd32767;
         d.clipped = 1'b1;
      end else if (y < -64'sd32768) begin
         y = -64'sd32768;
         d.clipped = 1'b1;
      end
      d.value = y[SAMPLE_W-1:0];
      due_results.push_back(d);
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SEND: begin
            send_idle_pct = 46;
            recv_stall_pct = 0;
         end
         IDLE_RECV: begin
            send_idle_pct = 0;
            recv_stall_pct = 46;
         end
         default: begin
            send_idle_pct = 24;
            recv_stall_pct = 24;
         end
      endcase
   endtask

   // Offer one sample, hold it until the transfer, then predict
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      filter_sample(s);
   endtask

   // Drop valid, wait for every pending result, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ratio(input logic [RATIO_W-1:0] r);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ratio_shadow = r;
   endtask

   // Compare one result transfer with the oldest prediction
   task automatic check_result();
      decimated_type want;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("result %0d with nothing pending",
                                   $signed(rsp_tdata)));
      end else begin
         want = due_results.pop_front();
         if (rsp_tdata !== want.value)
            report_mismatch($sformatf("filtered_out %0d, expected %0d",
                                      $signed(rsp_tdata), want.value));
         if (rsp_tuser !== want.clipped)
            report_mismatch($sformatf("saturated %0b, expected %0b",
                                      rsp_tuser, want.clipped));
      end
   endtask

   // Result side: check transfers, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Sample extremes under the reset ratio of ten
   task automatic test_default_ratio();
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh0000);
      send_sample(-16'sh0001);
      send_sample(16'sh0001);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
   endtask

   // Ratio one: every sample emits
   task automatic test_every_sample();
      write_ratio(8'd1);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh0001);
      send_sample(-16'sh0001);
   endtask

   // Ratio zero behaves as ratio one
   task automatic test_zero_ratio();
      write_ratio(8'd0);
      send_sample(-16'sh8000);
      send_sample(16'sh1234);
      send_sample(16'sh0000);
   endtask

   // Lower the ratio below the running count: next sample emits at once
   task automatic test_ratio_lowered();
      write_ratio(8'd8);
      repeat (5) send_sample(SAMPLE_W'($urandom));
      write_ratio(8'd2);
      send_sample(16'sh4000);
      send_sample(-16'sh4000);
      send_sample(16'sh0100);
   endtask

   task automatic run_random_phase(input logic [RATIO_W-1:0] r, input int n,
                                   input idle_mode_type mode);
      segment_kind_type           kind;
      int                         left;
      logic signed [SAMPLE_W-1:0] level;
      logic signed [SAMPLE_W-1:0] s;
      write_ratio(r);
      set_idling(mode);
      left = 0;
      kind = SEG_STEP;
      level = '0;
      for (int i = 0; i < n; i++) begin
         // Pick the next stretch: long steps, half of them full-scale, drive overshoot
         if (left == 0) begin
            case ($urandom_range(0, 3))
               0, 1: begin
                  kind = SEG_STEP;
                  left = $urandom_range(20, 90);
                  case ($urandom_range(0, 3))
                     0: level = 16'sh7FFF;
                     1: level = -16'sh8000;
                     default: level = SAMPLE_W'($urandom);
                  endcase
               end
               2: begin
                  kind = SEG_NOISE;
                  left = $urandom_range(5, 30);
               end
               default: begin
                  kind = SEG_QUIET;
                  left = $urandom_range(5, 30);
               end
            endcase
         end
         case (kind)
            SEG_STEP:  s = level;
            SEG_NOISE: s = SAMPLE_W'($urandom);
            default: begin
               s = SAMPLE_W'($urandom_range(0, 128));
               s = s - 16'sd64;
            end
         endcase
         send_sample(s);
         left--;
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(8'd1, 120, IDLE_NONE);
      run_random_phase(8'd2, 110, IDLE_RECV);
      run_random_phase(8'd4, 100, IDLE_SEND);
      run_random_phase(8'd6, 80, IDLE_BOTH);
      run_random_phase(8'd255, 260, IDLE_BOTH);
   endtask

   initial begin
      clear_filter_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_ratio();
      test_every_sample();
      test_zero_ratio();
      test_ratio_lowered();
      test_random_traffic();
      settle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/ild_pkg.sv
rtl/ild_ctrl.sv
rtl/ild_datapath.sv
rtl/iir_lowpass_decimator.sv
rtl/ild_checker.sv
tb/iir_lowpass_decimator_test.sv
